/* rtl/gft_pkg.sv */
// Shared types and constants of the grammar file tokenizer.
// Holds the lexer phase encoding, token kinds, error codes and the result record.
// Depends on nothing; every other file of the block imports it.
package gft_pkg;

    localparam int OUT_BITS  = 20;
    localparam int ADDR_BITS = 3;

    // Register index of the mode bit within the register map.
    localparam logic REG_MODE = 1'b0;

    typedef enum logic [15:0] {
        PH_START     = 16'b0000_0000_0000_0001,
        PH_IDENT     = 16'b0000_0000_0000_0010,
        PH_LITERAL   = 16'b0000_0000_0000_0100,
        PH_ACTION    = 16'b0000_0000_0000_1000,
        PH_SLASH     = 16'b0000_0000_0001_0000,
        PH_LINE      = 16'b0000_0000_0010_0000,
        PH_BLOCK     = 16'b0000_0000_0100_0000,
        PH_PCT       = 16'b0000_0000_1000_0000,
        PH_PCT_BRACE = 16'b0000_0001_0000_0000,
        PH_PREC_R    = 16'b0000_0010_0000_0000,
        PH_PREC_E    = 16'b0000_0100_0000_0000,
        PH_PREC_C    = 16'b0000_1000_0000_0000,
        PH_PREC_SP   = 16'b0001_0000_0000_0000,
        PH_PREC_BODY = 16'b0010_0000_0000_0000,
        PH_PCT_LINE  = 16'b0100_0000_0000_0000,
        PH_DONE      = 16'b1000_0000_0000_0000
    } t_phase;

    localparam logic [3:0] K_EOF     = 4'd0;
    localparam logic [3:0] K_NEWLINE = 4'd1;
    localparam logic [3:0] K_COLON   = 4'd2;
    localparam logic [3:0] K_PIPE    = 4'd3;
    localparam logic [3:0] K_SEMI    = 4'd4;
    localparam logic [3:0] K_IDENT   = 4'd5;
    localparam logic [3:0] K_LITERAL = 4'd6;
    localparam logic [3:0] K_ACTION  = 4'd7;
    localparam logic [3:0] K_COMMENT = 4'd8;
    localparam logic [3:0] K_DBL_PCT = 4'd9;
    localparam logic [3:0] K_DIRECT  = 4'd10;
    localparam logic [3:0] K_ASSIGN  = 4'd11;
    localparam logic [3:0] K_TERM    = 4'd12;

    localparam logic [1:0] E_NONE    = 2'd0;
    localparam logic [1:0] E_INVALID = 2'd1;
    localparam logic [1:0] E_EOF_IN  = 2'd2;
    localparam logic [1:0] E_PREC    = 2'd3;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LOW_C  = 8'h63;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_LOW_P  = 8'h70;
    localparam logic [7:0] CH_LOW_R  = 8'h72;

    typedef struct packed {
        logic [3:0]          kind;
        logic [OUT_BITS-1:0] offset;
        logic [OUT_BITS-1:0] length;
        logic [1:0]          err;
        logic                last;
    } t_result;

    function automatic logic word_byte(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h30 && b <= 8'h39) || b == 8'h5F;
    endfunction

endpackage

/* rtl/gft_lexer.sv */
// Lexer state and combinational next-state logic of the grammar file tokenizer.
// Produces up to two result records for each accepted byte or end mark.
// Depends on gft_pkg.
module gft_lexer #(
    parameter int POSITION_BITS = 20,
    parameter int DEPTH_BITS    = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_mode,
    input  logic            i_accept,
    input  logic [7:0]      i_char_byte,
    input  logic            i_at_end,
    output logic [1:0]      o_res_count,
    output gft_pkg::t_result o_res0,
    output gft_pkg::t_result o_res1
);
    import gft_pkg::*;

    t_phase                   r_phase, n_phase;
    logic [DEPTH_BITS-1:0]    r_depth, n_depth;
    logic [1:0]               r_colons, n_colons;
    logic [POSITION_BITS-1:0] r_begin, n_begin;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic                     r_quote, n_quote;
    logic                     r_star, n_star;
    logic                     r_halted, n_halted;

    logic [POSITION_BITS-1:0] pos_next;
    logic                     chain;
    logic                     is_word;

    // Outputs of the start-phase decoder.
    logic [POSITION_BITS-1:0] s_begin_in, s_begin;
    logic [1:0]               s_colons_in, s_colons;
    t_phase                   s_phase;
    logic                     s_depth_one;
    logic                     s_halt;
    logic                     s_valid;
    t_result                  s_res;

    t_result                  res0, res1;
    logic [1:0]               res_count;

    function automatic t_result make_tok(input logic [3:0] kind,
                                         input logic [POSITION_BITS-1:0] beg,
                                         input logic [POSITION_BITS-1:0] fin);
        t_result                  r;
        logic [POSITION_BITS-1:0] d;
        logic [31:0]              w_off;
        logic [31:0]              w_len;
        d        = fin - beg;
        w_off    = 32'(beg);
        w_len    = 32'(d);
        r.kind   = kind;
        r.offset = w_off[OUT_BITS-1:0];
        r.length = w_len[OUT_BITS-1:0];
        r.err    = E_NONE;
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic t_result make_err(input logic [1:0] code,
                                         input logic [POSITION_BITS-1:0] pos);
        t_result     r;
        logic [31:0] w_off;
        w_off    = 32'(pos);
        r.kind   = K_EOF;
        r.offset = w_off[OUT_BITS-1:0];
        r.length = '0;
        r.err    = code;
        r.last   = 1'b0;
        return r;
    endfunction

    assign pos_next = r_pos + POSITION_BITS'(1);
    assign is_word  = word_byte(i_char_byte);

    // A byte that closes an identifier, a line comment or a precedence operand
    // emits that token and is then decoded again from the start phase.
    always_comb begin
        chain = 1'b0;
        if (r_phase == PH_IDENT) begin
            chain = i_at_end || !is_word;
        end else if (r_phase == PH_LINE) begin
            chain = i_at_end || i_char_byte == CH_NL;
        end else if (r_phase == PH_PREC_BODY) begin
            chain = !r_quote && (i_at_end || (i_char_byte != CH_QUOTE && !is_word));
        end
    end

    assign s_begin_in  = chain ? r_pos : r_begin;
    assign s_colons_in = chain ? 2'd0 : r_colons;

    always_comb begin
        s_phase     = PH_START;
        s_colons    = s_colons_in;
        s_begin     = s_begin_in;
        s_depth_one = 1'b0;
        s_halt      = 1'b0;
        s_valid     = 1'b0;
        s_res       = '0;
        if (i_at_end) begin
            s_valid  = 1'b1;
            s_res    = make_tok(K_EOF, s_begin_in, r_pos);
            s_phase  = PH_DONE;
            s_begin  = r_pos;
            s_colons = 2'd0;
        end else if (i_char_byte == CH_SLASH) begin
            s_phase  = PH_SLASH;
            s_colons = 2'd0;
        end else if (i_char_byte == CH_NL) begin
            s_valid  = 1'b1;
            s_res    = make_tok(K_NEWLINE, s_begin_in, pos_next);
            s_begin  = pos_next;
            s_colons = 2'd0;
        end else if (i_char_byte == CH_SPACE || i_char_byte == CH_TAB) begin
            s_begin = pos_next;
        end else if (is_word) begin
            s_phase  = PH_IDENT;
            s_colons = 2'd0;
        end else if (i_char_byte == CH_QUOTE) begin
            s_phase  = PH_LITERAL;
            s_colons = 2'd0;
        end else if (!i_mode) begin
            priority if (i_char_byte == CH_PCT) begin
                s_phase  = PH_PCT;
                s_colons = 2'd0;
            end else if (i_char_byte == CH_COLON || i_char_byte == CH_PIPE ||
                         i_char_byte == CH_SEMI) begin
                s_valid  = 1'b1;
                s_res    = make_tok(i_char_byte == CH_COLON ? K_COLON :
                                    i_char_byte == CH_PIPE  ? K_PIPE : K_SEMI,
                                    s_begin_in, pos_next);
                s_begin  = pos_next;
                s_colons = 2'd0;
            end else if (i_char_byte == CH_LBRACE) begin
                s_phase     = PH_ACTION;
                s_colons    = 2'd0;
                s_depth_one = 1'b1;
            end else begin
                s_valid = 1'b1;
                s_res   = make_err(E_INVALID, r_pos);
                s_halt  = 1'b1;
            end
        end else begin
            // Colons are held back and become part of the next token's text.
            priority if (i_char_byte == CH_COLON && s_colons_in < 2'd2) begin
                s_colons = s_colons_in + 2'd1;
            end else if (i_char_byte == CH_EQUALS && s_colons_in == 2'd2) begin
                s_valid  = 1'b1;
                s_res    = make_tok(K_ASSIGN, s_begin_in, pos_next);
                s_begin  = pos_next;
                s_colons = 2'd0;
            end else if (i_char_byte == CH_PIPE || i_char_byte == CH_DOT) begin
                s_valid  = 1'b1;
                s_res    = make_tok(i_char_byte == CH_PIPE ? K_PIPE : K_TERM,
                                    s_begin_in, pos_next);
                s_begin  = pos_next;
                s_colons = 2'd0;
            end else if (i_char_byte == CH_LBRACK || i_char_byte == CH_RBRACK) begin
                s_begin = pos_next;
            end else begin
                s_valid = 1'b1;
                s_res   = make_err(E_INVALID, r_pos);
                s_halt  = 1'b1;
            end
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_depth   = r_depth;
        n_colons  = r_colons;
        n_begin   = r_begin;
        n_pos     = r_pos;
        n_quote   = r_quote;
        n_star    = r_star;
        n_halted  = r_halted;
        res0      = '0;
        res1      = '0;
        res_count = 2'd0;
        if (i_accept && !r_halted && r_phase != PH_DONE) begin
            if (!i_at_end) begin
                n_pos = pos_next;
            end
            if (chain) begin
                res0      = make_tok(r_phase == PH_IDENT ? K_IDENT :
                                     r_phase == PH_LINE  ? K_COMMENT : K_DIRECT,
                                     r_begin, r_pos);
                res1      = s_res;
                res_count = s_valid ? 2'd2 : 2'd1;
                n_phase   = s_phase;
                n_colons  = s_colons;
                n_begin   = s_begin;
                n_halted  = s_halt;
                if (s_depth_one) begin
                    n_depth = DEPTH_BITS'(1);
                end
            end else begin
                unique case (r_phase)
                    PH_START: begin
                        res0      = s_res;
                        res_count = {1'b0, s_valid};
                        n_phase   = s_phase;
                        n_colons  = s_colons;
                        n_begin   = s_begin;
                        n_halted  = s_halt;
                        if (s_depth_one) begin
                            n_depth = DEPTH_BITS'(1);
                        end
                    end
                    PH_IDENT, PH_LINE, PH_DONE: begin
                    end
                    PH_LITERAL: begin
                        if (i_at_end) begin
                            res0     = make_err(E_EOF_IN, r_pos);
                            n_halted = 1'b1;
                            res_count = 2'd1;
                        end else if (i_char_byte == CH_QUOTE) begin
                            res0      = make_tok(K_LITERAL, r_begin, pos_next);
                            res_count = 2'd1;
                            n_begin   = pos_next;
                            n_colons  = 2'd0;
                            n_phase   = PH_START;
                        end
                    end
                    PH_ACTION: begin
                        if (i_at_end) begin
                            res0      = make_err(E_EOF_IN, r_pos);
                            n_halted  = 1'b1;
                            res_count = 2'd1;
                        end else if (i_char_byte == CH_LBRACE) begin
                            if (r_depth != '1) begin
                                n_depth = r_depth + DEPTH_BITS'(1);
                            end
                        end else if (i_char_byte == CH_RBRACE) begin
                            if (r_depth != '0) begin
                                n_depth = r_depth - DEPTH_BITS'(1);
                            end
                            if (r_depth == '0 || r_depth == DEPTH_BITS'(1)) begin
                                res0      = make_tok(K_ACTION, r_begin, pos_next);
                                res_count = 2'd1;
                                n_begin   = pos_next;
                                n_colons  = 2'd0;
                                n_phase   = PH_START;
                            end
                        end
                    end
                    PH_SLASH: begin
                        if (i_at_end) begin
                            res0      = make_err(E_EOF_IN, r_pos);
                            n_halted  = 1'b1;
                            res_count = 2'd1;
                        end else if (i_char_byte == CH_SLASH) begin
                            n_phase = PH_LINE;
                        end else if (i_char_byte == CH_STAR) begin
                            n_phase = PH_BLOCK;
                            n_star  = 1'b0;
                        end else begin
                            res0      = make_err(E_INVALID, r_pos);
                            n_halted  = 1'b1;
                            res_count = 2'd1;
                        end
                    end
                    PH_BLOCK: begin
                        if (i_at_end) begin
                            res0      = make_err(E_EOF_IN, r_pos);
                            n_halted  = 1'b1;
                            res_count = 2'd1;
                        end else if (r_star && i_char_byte == CH_SLASH) begin
                            n_star    = 1'b0;
                            res0      = make_tok(K_COMMENT, r_begin, pos_next);
                            res_count = 2'd1;
                            n_begin   = pos_next;
                            n_colons  = 2'd0;
                            n_phase   = PH_START;
                        end else begin
                            n_star = (i_char_byte == CH_STAR);
                        end
                    end
                    PH_PCT: begin
                        if (i_at_end) begin
                            res0      = make_err(E_EOF_IN, r_pos);
                            n_halted  = 1'b1;
                            res_count = 2'd1;
                        end else if (i_char_byte == CH_PCT) begin
                            res0      = make_tok(K_DBL_PCT, r_begin, pos_next);
                            res_count = 2'd1;
                            n_begin   = pos_next;
                            n_colons  = 2'd0;
                            n_phase   = PH_START;
                        end else if (i_char_byte == CH_LBRACE) begin
                            n_phase = PH_PCT_BRACE;
                            n_star  = 1'b0;
                        end else if (i_char_byte == CH_LOW_P) begin
                            n_phase = PH_PREC_R;
                        end else begin
                            n_phase = PH_PCT_LINE;
                            n_depth = '0;
                        end
                    end
                    PH_PCT_BRACE: begin
                        if (i_at_end) begin
                            res0      = make_err(E_EOF_IN, r_pos);
                            n_halted  = 1'b1;
                            res_count = 2'd1;
                        end else if (r_star && i_char_byte == CH_RBRACE) begin
                            n_star    = 1'b0;
                            res0      = make_tok(K_DIRECT, r_begin, pos_next);
                            res_count = 2'd1;
                            n_begin   = pos_next;
                            n_colons  = 2'd0;
                            n_phase   = PH_START;
                        end else begin
                            n_star = (i_char_byte == CH_PCT);
                        end
                    end
                    PH_PREC_R, PH_PREC_E, PH_PREC_C: begin
                        if (i_at_end ||
                            (r_phase == PH_PREC_R && i_char_byte != CH_LOW_R) ||
                            (r_phase == PH_PREC_E && i_char_byte != CH_LOW_E) ||
                            (r_phase == PH_PREC_C && i_char_byte != CH_LOW_C)) begin
                            res0      = make_err(E_PREC, r_pos);
                            n_halted  = 1'b1;
                            res_count = 2'd1;
                        end else begin
                            n_phase = (r_phase == PH_PREC_R) ? PH_PREC_E :
                                      (r_phase == PH_PREC_E) ? PH_PREC_C : PH_PREC_SP;
                        end
                    end
                    PH_PREC_SP: begin
                        if (i_at_end ||
                            (i_char_byte != CH_SPACE && i_char_byte != CH_TAB)) begin
                            res0      = make_err(E_PREC, r_pos);
                            n_halted  = 1'b1;
                            res_count = 2'd1;
                        end else begin
                            n_phase = PH_PREC_BODY;
                            n_quote = 1'b0;
                        end
                    end
                    PH_PREC_BODY: begin
                        // Only the cases that do not close the operand arrive here.
                        if (i_at_end) begin
                            res0      = make_err(E_EOF_IN, r_pos);
                            n_halted  = 1'b1;
                            res_count = 2'd1;
                        end else if (i_char_byte == CH_QUOTE) begin
                            n_quote = !r_quote;
                        end
                    end
                    PH_PCT_LINE: begin
                        if (i_at_end) begin
                            res0      = make_err(E_EOF_IN, r_pos);
                            n_halted  = 1'b1;
                            res_count = 2'd1;
                        end else if (i_char_byte == CH_LBRACE) begin
                            if (r_depth != '1) begin
                                n_depth = r_depth + DEPTH_BITS'(1);
                            end
                        end else if ((i_char_byte == CH_RBRACE &&
                                      r_depth == DEPTH_BITS'(1)) ||
                                     (i_char_byte == CH_NL && r_depth == '0)) begin
                            n_depth   = '0;
                            res0      = make_tok(K_DIRECT, r_begin, pos_next);
                            res_count = 2'd1;
                            n_begin   = pos_next;
                            n_colons  = 2'd0;
                            n_phase   = PH_START;
                        end else if (i_char_byte == CH_RBRACE && r_depth != '0) begin
                            n_depth = r_depth - DEPTH_BITS'(1);
                        end
                    end
                    default: begin
                        n_phase = PH_START;
                    end
                endcase
            end
            if (res_count == 2'd1) begin
                res0.last = 1'b1;
            end else if (res_count == 2'd2) begin
                res1.last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_depth  <= '0;
            r_colons <= 2'd0;
            r_begin  <= '0;
            r_pos    <= '0;
            r_quote  <= 1'b0;
            r_star   <= 1'b0;
            r_halted <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_depth  <= n_depth;
            r_colons <= n_colons;
            r_begin  <= n_begin;
            r_pos    <= n_pos;
            r_quote  <= n_quote;
            r_star   <= n_star;
            r_halted <= n_halted;
        end
    end

    assign o_res_count = res_count;
    assign o_res0      = res0;
    assign o_res1      = res1;

endmodule

/* rtl/gft_res_fifo.sv */
// Result queue of the grammar file tokenizer: four entries, up to two written
// per cycle, one read per cycle. Depends on gft_pkg.
module gft_res_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_count,
    input  gft_pkg::t_result i_push0,
    input  gft_pkg::t_result i_push1,
    input  logic             i_pop,
    output logic             o_not_empty,
    output logic             o_full2,
    output gft_pkg::t_result o_head
);
    import gft_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [PTR_W-1:0]   wptr1;
    logic               do_pop;

    assign do_pop = i_pop && r_count != '0;
    assign wptr1  = r_wptr + PTR_W'(1);

    always_comb begin
        n_wptr  = r_wptr + PTR_W'(i_push_count);
        n_rptr  = do_pop ? r_rptr + PTR_W'(1) : r_rptr;
        n_count = r_count + CNT_W'(i_push_count) - CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wptr] <= i_push0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[wptr1] <= i_push1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    assign o_not_empty = r_count != '0;
    // Stall upstream unless two entries are free, since one beat may yield two results.
    assign o_full2     = r_count > CNT_W'(DEPTH - 2);
    assign o_head      = r_mem[r_rptr];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result queue count beyond depth");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full2 |-> i_push_count == 2'd0)
        else $error("result pushed while queue lacked room");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && i_push_count == 2'd0) |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("queue count did not fall on a lone read");

endmodule

/* rtl/grammar_file_tokenizer_unit.sv */
// Top level of the grammar file tokenizer: configuration port, lexer and result queue.
// Depends on gft_pkg, gft_lexer and gft_res_fifo.
//
// The block takes one byte of grammar text (or an end mark) per beat and returns zero,
// one or two token beats for it. A new input beat can be taken every clock cycle while the
// input is not stalled; its results are registered into a four-entry queue as it is taken,
// and the input stalls while fewer than two entries are free, so a stream of bytes that
// each give at most one token runs at one byte per cycle while the output is not stalled,
// and bytes that give two tokens can stall the input. After an error result or the
// end-of-file token the block gives no further results until reset.
// The mode register sits at byte address 0 and should be written only while idle.
module grammar_file_tokenizer_unit #(
    parameter int POSITION_BITS = 20,
    parameter int DEPTH_BITS    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gft_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_char_byte,
    input  logic                          i_at_end,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [3:0]                    o_token_kind,
    output logic [gft_pkg::OUT_BITS-1:0]  o_token_offset,
    output logic [gft_pkg::OUT_BITS-1:0]  o_token_length,
    output logic [1:0]                    o_error_code,
    output logic                          o_last
);
    import gft_pkg::*;

    logic       r_mode;
    logic       reg_sel_mode;
    logic       accept;
    logic       full2;
    logic [1:0] res_count;
    logic [1:0] push_count;
    t_result    res0, res1, head;

    assign pready       = 1'b1;
    assign reg_sel_mode = paddr[ADDR_BITS-1] == REG_MODE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (psel && penable && pwrite && reg_sel_mode) begin
            r_mode <= pwdata[0];
        end
    end

    assign prdata = reg_sel_mode ? {31'd0, r_mode} : 32'd0;

    assign o_in_stall = full2;
    assign accept     = i_in_valid && !full2;

    gft_lexer #(
        .POSITION_BITS (POSITION_BITS),
        .DEPTH_BITS    (DEPTH_BITS)
    ) u_lexer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_mode),
        .i_accept    (accept),
        .i_char_byte (i_char_byte),
        .i_at_end    (i_at_end),
        .o_res_count (res_count),
        .o_res0      (res0),
        .o_res1      (res1)
    );

    assign push_count = accept ? res_count : 2'd0;

    gft_res_fifo u_res_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_push0      (res0),
        .i_push1      (res1),
        .i_pop        (!i_out_stall),
        .o_not_empty  (o_out_valid),
        .o_full2      (full2),
        .o_head       (head)
    );

    assign o_token_kind   = head.kind;
    assign o_token_offset = head.offset;
    assign o_token_length = head.length;
    assign o_error_code   = head.err;
    assign o_last         = head.last;

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for grammar_file_tokenizer_unit: byte beats in, token beats out.
// Depends on gft_pkg and the tokenizer RTL; it keeps its own model of the lexer.
module tb;
    import gft_pkg::*;

    localparam logic [7:0] CH_AT = 8'h40;
    localparam logic [7:0] DEPTH_TOP = '1;
    localparam logic [ADDR_BITS-1:0] MODE_ADDR = ADDR_BITS'(4 * REG_MODE);

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } t_text_beat;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [7:0]          i_char_byte = '0;
    logic                i_at_end = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [3:0]          o_token_kind;
    logic [OUT_BITS-1:0] o_token_offset;
    logic [OUT_BITS-1:0] o_token_length;
    logic [1:0]          o_error_code;
    logic                o_last;

    // Lexer model state.
    t_phase              lex_phase = PH_START;
    logic                gram_mode = 1'b0;
    logic [7:0]          brace_depth = '0;
    logic [1:0]          colon_count = '0;
    logic [OUT_BITS-1:0] tok_start = '0;
    logic [OUT_BITS-1:0] byte_pos = '0;
    logic                quote_open = 1'b0;
    logic                star_seen = 1'b0;
    logic                lex_halted = 1'b0;
    t_result             step_tokens[$];
    t_result             tokens_due[$];

    t_text_beat          text_beats[$];
    t_text_beat          next_beat;
    t_result             want_tok;
    int unsigned         gap_pct = 0;
    int unsigned         stall_pct = 0;
    int unsigned         mismatches = 0;
    logic                hold_go = 1'b0;
    int unsigned         hold_left = 0;

    grammar_file_tokenizer_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_char_byte    (i_char_byte),
        .i_at_end       (i_at_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_token_kind   (o_token_kind),
        .o_token_offset (o_token_offset),
        .o_token_length (o_token_length),
        .o_error_code   (o_error_code),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic is_name_char(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == 8'h5F;
    endfunction

    function automatic void close_token(logic [3:0] kind, logic [OUT_BITS-1:0] end_pos);
        t_result r;
        r.kind = kind;
        r.offset = tok_start;
        r.length = end_pos - tok_start;
        r.err = E_NONE;
        r.last = 1'b0;
        step_tokens.push_back(r);
        tok_start = end_pos;
        colon_count = '0;
        lex_phase = PH_START;
    endfunction

    function automatic void raise_error(logic [1:0] code);
        t_result r;
        r.kind = K_EOF;
        r.offset = byte_pos;
        r.length = '0;
        r.err = code;
        r.last = 1'b0;
        step_tokens.push_back(r);
        lex_halted = 1'b1;
    endfunction

    function automatic void open_phase(t_phase p);
        lex_phase = p;
        colon_count = '0;
    endfunction

    // A byte seen from the start phase, also used for the byte that closes a token.
    function automatic void lex_fresh(logic [7:0] b, logic eof);
        logic [OUT_BITS-1:0] nxt;
        nxt = byte_pos + 1'b1;
        if (eof) begin
            close_token(K_EOF, byte_pos);
            lex_phase = PH_DONE;
        end else if (b == CH_SLASH) open_phase(PH_SLASH);
        else if (b == CH_NL) close_token(K_NEWLINE, nxt);
        else if (b == CH_SPACE || b == CH_TAB) tok_start = nxt;
        else if (is_name_char(b)) open_phase(PH_IDENT);
        else if (b == CH_QUOTE) open_phase(PH_LITERAL);
        else if (!gram_mode) begin
            if (b == CH_PCT) open_phase(PH_PCT);
            else if (b == CH_COLON) close_token(K_COLON, nxt);
            else if (b == CH_PIPE) close_token(K_PIPE, nxt);
            else if (b == CH_LBRACE) begin
                open_phase(PH_ACTION);
                brace_depth = 8'd1;
            end else if (b == CH_SEMI) close_token(K_SEMI, nxt);
            else raise_error(E_INVALID);
        end else begin
            // Colons are neither emitted nor skipped; they count towards "::=".
            if (b == CH_COLON) begin
                if (colon_count < 2) colon_count = colon_count + 1'b1;
                else raise_error(E_INVALID);
            end else if (b == CH_EQUALS) begin
                if (colon_count == 2) close_token(K_ASSIGN, nxt);
                else raise_error(E_INVALID);
            end else if (b == CH_PIPE) close_token(K_PIPE, nxt);
            else if (b == CH_DOT) close_token(K_TERM, nxt);
            else if (b == CH_LBRACK || b == CH_RBRACK) tok_start = nxt;
            else raise_error(E_INVALID);
        end
    endfunction

    function automatic void lex_beat(logic [7:0] b, logic eof);
        logic [OUT_BITS-1:0] nxt;
        t_result r;
        nxt = byte_pos + 1'b1;
        step_tokens.delete();
        if (lex_halted || lex_phase == PH_DONE) return;
        case (lex_phase)
            PH_IDENT: begin
                if (eof || !is_name_char(b)) begin
                    close_token(K_IDENT, byte_pos);
                    lex_fresh(b, eof);
                end
            end
            PH_LITERAL: begin
                if (eof) raise_error(E_EOF_IN);
                else if (b == CH_QUOTE) close_token(K_LITERAL, nxt);
            end
            PH_ACTION: begin
                if (eof) raise_error(E_EOF_IN);
                else if (b == CH_LBRACE) begin
                    if (brace_depth != DEPTH_TOP) brace_depth = brace_depth + 1'b1;
                end else if (b == CH_RBRACE) begin
                    if (brace_depth != 0) brace_depth = brace_depth - 1'b1;
                    if (brace_depth == 0) close_token(K_ACTION, nxt);
                end
            end
            PH_SLASH: begin
                if (eof) raise_error(E_EOF_IN);
                else if (b == CH_SLASH) lex_phase = PH_LINE;
                else if (b == CH_STAR) begin
                    lex_phase = PH_BLOCK;
                    star_seen = 1'b0;
                end else raise_error(E_INVALID);
            end
            PH_LINE: begin
                if (eof || b == CH_NL) begin
                    close_token(K_COMMENT, byte_pos);
                    lex_fresh(b, eof);
                end
            end
            PH_BLOCK: begin
                if (eof) raise_error(E_EOF_IN);
                else if (star_seen && b == CH_SLASH) begin
                    star_seen = 1'b0;
                    close_token(K_COMMENT, nxt);
                end else star_seen = (b == CH_STAR);
            end
            PH_PCT: begin
                if (eof) raise_error(E_EOF_IN);
                else if (b == CH_PCT) close_token(K_DBL_PCT, nxt);
                else if (b == CH_LBRACE) begin
                    lex_phase = PH_PCT_BRACE;
                    star_seen = 1'b0;
                end else if (b == CH_LOW_P) lex_phase = PH_PREC_R;
                else begin
                    lex_phase = PH_PCT_LINE;
                    brace_depth = '0;
                end
            end
            PH_PCT_BRACE: begin
                if (eof) raise_error(E_EOF_IN);
                else if (star_seen && b == CH_RBRACE) begin
                    star_seen = 1'b0;
                    close_token(K_DIRECT, nxt);
                end else star_seen = (b == CH_PCT);
            end
            PH_PREC_R: begin
                if (eof || b != CH_LOW_R) raise_error(E_PREC);
                else lex_phase = PH_PREC_E;
            end
            PH_PREC_E: begin
                if (eof || b != CH_LOW_E) raise_error(E_PREC);
                else lex_phase = PH_PREC_C;
            end
            PH_PREC_C: begin
                if (eof || b != CH_LOW_C) raise_error(E_PREC);
                else lex_phase = PH_PREC_SP;
            end
            PH_PREC_SP: begin
                if (eof || (b != CH_SPACE && b != CH_TAB)) raise_error(E_PREC);
                else begin
                    lex_phase = PH_PREC_BODY;
                    quote_open = 1'b0;
                end
            end
            PH_PREC_BODY: begin
                if (eof) begin
                    if (quote_open) raise_error(E_EOF_IN);
                    else begin
                        close_token(K_DIRECT, byte_pos);
                        lex_fresh(b, 1'b1);
                    end
                end else if (b == CH_QUOTE) quote_open = !quote_open;
                else if (!quote_open && !is_name_char(b)) begin
                    close_token(K_DIRECT, byte_pos);
                    lex_fresh(b, 1'b0);
                end
            end
            PH_PCT_LINE: begin
                if (eof) raise_error(E_EOF_IN);
                else if (b == CH_LBRACE) begin
                    if (brace_depth != DEPTH_TOP) brace_depth = brace_depth + 1'b1;
                end else if (b == CH_RBRACE) begin
                    // A closing brace with nothing open is simply dropped.
                    if (brace_depth != 0) begin
                        brace_depth = brace_depth - 1'b1;
                        if (brace_depth == 0) close_token(K_DIRECT, nxt);
                    end
                end else if (b == CH_NL && brace_depth == 0) close_token(K_DIRECT, nxt);
            end
            default: lex_fresh(b, eof);
        endcase
        if (!eof) byte_pos = nxt;
        foreach (step_tokens[i]) begin
            r = step_tokens[i];
            r.last = (i == step_tokens.size() - 1);
            tokens_due.push_back(r);
        end
    endfunction

    function automatic void put_char(logic [7:0] c);
        t_text_beat t;
        t.ch = c;
        t.fin = 1'b0;
        text_beats.push_back(t);
    endfunction

    function automatic void put_end();
        t_text_beat t;
        t.ch = 8'($urandom_range(255));
        t.fin = 1'b1;
        text_beats.push_back(t);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
    endfunction

    function automatic logic [7:0] rand_byte_not(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        logic [7:0] r;
        r = 8'($urandom_range(255));
        while (r == a || r == b || r == c) r = 8'($urandom_range(255));
        return r;
    endfunction

    function automatic logic [7:0] rand_name_char();
        int unsigned r;
        r = $urandom_range(62);
        if (r < 26) return 8'(32'h61 + r);
        if (r < 52) return 8'(32'h41 + r - 26);
        if (r < 62) return 8'(32'h30 + r - 52);
        return 8'h5F;
    endfunction

    function automatic void put_ident();
        repeat ($urandom_range(1, 6)) put_char(rand_name_char());
    endfunction

    function automatic void put_literal();
        put_char(CH_QUOTE);
        repeat ($urandom_range(0, 5)) put_char(rand_byte_not(CH_QUOTE, CH_QUOTE, CH_QUOTE));
        put_char(CH_QUOTE);
    endfunction

    function automatic void put_line_comment();
        put_text("//");
        repeat ($urandom_range(0, 6)) put_char(rand_byte_not(CH_NL, CH_NL, CH_NL));
        put_char(CH_NL);
    endfunction

    // Body bytes of a comment or a %{ block must not close it early.
    function automatic void put_guarded(logic [7:0] opener, logic [7:0] closer);
        logic [7:0] prev;
        logic [7:0] c;
        prev = '0;
        repeat ($urandom_range(0, 8)) begin
            c = 8'($urandom_range(255));
            if (prev == opener && c == closer) c = CH_SPACE;
            put_char(c);
            prev = c;
        end
    endfunction

    function automatic void put_nested(int unsigned depth_cap, logic [7:0] filler_skip);
        int unsigned d;
        int unsigned r;
        d = 0;
        repeat ($urandom_range(0, 8)) begin
            r = $urandom_range(5);
            if (r == 0 && d < depth_cap) begin
                put_char(CH_LBRACE);
                d++;
            end else if (r == 1 && d > 0) begin
                put_char(CH_RBRACE);
                d--;
            end else put_char(rand_byte_not(CH_LBRACE, CH_RBRACE, filler_skip));
        end
        repeat (d + 1) put_char(CH_RBRACE);
    endfunction

    function automatic void put_prec();
        logic [7:0] ends[6];
        ends = '{CH_SPACE, CH_TAB, CH_NL, CH_COLON, CH_PIPE, CH_SEMI};
        put_text("%prec");
        put_char($urandom_range(1) ? CH_SPACE : CH_TAB);
        repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(2) == 0) begin
                put_char(CH_QUOTE);
                repeat ($urandom_range(0, 3))
                    put_char(rand_byte_not(CH_QUOTE, CH_QUOTE, CH_QUOTE));
                put_char(CH_QUOTE);
            end else put_ident();
        end
        put_char(ends[$urandom_range(5)]);
    endfunction

    function automatic void put_pct_line();
        put_char(CH_PCT);
        put_char(rand_byte_not(CH_PCT, CH_LBRACE, CH_LOW_P));
        repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(7) == 0) put_char(CH_RBRACE);
            else put_char(rand_byte_not(CH_NL, CH_LBRACE, CH_RBRACE));
        end
        // Either a newline or a balanced brace group finishes the directive.
        if ($urandom_range(1)) put_char(CH_NL);
        else begin
            put_char(CH_LBRACE);
            put_nested(2, CH_LBRACE);
        end
    endfunction

    function automatic void fill_random(int unsigned n);
        int unsigned target;
        target = text_beats.size() + n;
        while (text_beats.size() < target) begin
            if (gram_mode) begin
                case ($urandom_range(9))
                    0, 1, 2: put_ident();
                    3: put_literal();
                    4: put_line_comment();
                    5: begin
                        put_text("/*");
                        put_guarded(CH_STAR, CH_SLASH);
                        put_text("*/");
                    end
                    6: put_text("::=");
                    7: put_char($urandom_range(1) ? CH_PIPE : CH_DOT);
                    8: begin
                        case ($urandom_range(3))
                            0: put_char(CH_SPACE);
                            1: put_char(CH_TAB);
                            2: put_char(CH_LBRACK);
                            default: put_char(CH_RBRACK);
                        endcase
                    end
                    default: put_char(CH_NL);
                endcase
            end else begin
                case ($urandom_range(15))
                    0, 1, 2: put_ident();
                    3: put_literal();
                    4: begin
                        put_char(CH_LBRACE);
                        put_nested(3, CH_LBRACE);
                    end
                    5: put_line_comment();
                    6: begin
                        put_text("/*");
                        put_guarded(CH_STAR, CH_SLASH);
                        put_text("*/");
                    end
                    7: put_text("%%");
                    8: begin
                        put_text("%{");
                        put_guarded(CH_PCT, CH_RBRACE);
                        put_text("%}");
                    end
                    9: put_prec();
                    10: put_pct_line();
                    11: put_char($urandom_range(1) ? CH_SPACE : CH_TAB);
                    12: put_char(CH_NL);
                    13: put_char(CH_COLON);
                    14: put_char(CH_PIPE);
                    default: put_char(CH_SEMI);
                endcase
            end
        end
    endfunction

    // One way of finishing the text: an end mark or an error, then beats that are ignored.
    function automatic void put_ending();
        if (gram_mode) begin
            case ($urandom_range(5))
                0: put_text(":::");
                1: put_char(CH_EQUALS);
                2: put_char(CH_PCT);
                3: put_char(CH_SEMI);
                4: put_text("'a");
                default: put_ident();
            endcase
        end else begin
            case ($urandom_range(13))
                0: ;
                1: put_ident();
                2: put_text("//x");
                3: put_text("'ab");
                4: put_text("{{}");
                5: put_text("/*x*");
                6: put_text("/");
                7: put_text("%prec");
                8: put_text("%px");
                9: put_text("%prec a'b");
                10: put_text("%prec ab");
                11: put_char(CH_AT);
                12: put_text("%{a");
                default: put_text("%x");
            endcase
        end
        put_end();
        repeat (4) put_char(8'($urandom_range(255)));
        put_end();
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic write_mode(input logic m);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MODE_ADDR;
        pwdata <= {31'b0, m};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        gram_mode = m;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("mode readback", {31'b0, m}, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        int unsigned waited;
        waited = 0;
        while ((text_beats.size() != 0 || i_in_valid || tokens_due.size() != 0) &&
               waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (6) @(posedge i_clk);
        if (tokens_due.size() != 0) begin
            $display("%0t: expected %0d more token beats, actual none", $time,
                     tokens_due.size());
            mismatches++;
            tokens_due.delete();
        end
    endtask

    task automatic set_pace(input int unsigned gap, input int unsigned stall);
        gap_pct <= gap;
        stall_pct <= stall;
    endtask

    // Sender: offers the next pending byte beat when the slot is free, holding back at random by the gap percentage.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) lex_beat(i_char_byte, i_at_end);
            if (!i_in_valid || !o_in_stall) begin
                if (text_beats.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    next_beat = text_beats.pop_front();
                    i_in_valid <= 1'b1;
                    i_char_byte <= next_beat.ch;
                    i_at_end <= next_beat.fin;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each token beat against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (tokens_due.size() == 0) begin
                    $display("%0t: expected no token, actual kind %0d offset %0d",
                             $time, o_token_kind, o_token_offset);
                    mismatches++;
                end else begin
                    want_tok = tokens_due.pop_front();
                    check_field("kind", 32'(want_tok.kind), 32'(o_token_kind));
                    check_field("offset", 32'(want_tok.offset), 32'(o_token_offset));
                    check_field("length", 32'(want_tok.length), 32'(o_token_length));
                    check_field("error", 32'(want_tok.err), 32'(o_error_code));
                    check_field("last", 32'(want_tok.last), 32'(o_last));
                end
            end
            i_out_stall <= hold_left != 0 || $urandom_range(99) < stall_pct;
        end
    end

    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_left <= 300;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_mode(1'b0);
        @(negedge i_clk);
        put_text("A_z9 : |\t;\n'");
        put_char(8'h00);
        put_char(8'hFF);
        put_text("'{ {}}/**/ //c\n%%%{%}%prec x\t%n}\n");
        drain();

        write_mode(1'b1);
        @(negedge i_clk);
        put_text("a ::=[b].\t|'q'//z\n");
        fill_random(80);
        drain();

        set_pace(57, 0);
        write_mode(1'b0);
        @(negedge i_clk);
        fill_random(40);
        // Nesting beyond the counter's range: the depth saturates, so a full
        // count of closing braces is enough to finish the action.
        repeat (260) put_char(CH_LBRACE);
        repeat (255) put_char(CH_RBRACE);
        fill_random(40);
        drain();

        set_pace(0, 57);
        write_mode(1'b1);
        @(negedge i_clk);
        fill_random(120);
        drain();

        set_pace(38, 38);
        write_mode(1'b0);
        @(negedge i_clk);
        fill_random(120);
        drain();

        // Receiver holds off for a long stretch while the sender keeps offering.
        set_pace(0, 0);
        write_mode(1'b1);
        @(negedge i_clk);
        fill_random(160);
        @(posedge i_clk);
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
        drain();

        set_pace(20, 20);
        write_mode(1'($urandom_range(1)));
        @(negedge i_clk);
        fill_random(100);
        put_ending();
        drain();

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
